// ===== rtl/core/double_ended_queue_with_remove_macros.svh =====
// assertion macros for the double-ended queue rtl
`ifndef DOUBLE_ENDED_QUEUE_WITH_REMOVE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_REMOVE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/deq_pkg.sv =====
// package with types and constants of the double-ended queue
package deq_pkg;

  localparam int DEQ_DEPTH  = 16;
  localparam int DEQ_DATA_W = 32;

  // request codes
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_REMOVE     = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_type_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  // control sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_SCAN
  } fsm_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic [4:0]  removed_count;
    logic        is_empty;
  } out_beat_t;

endpackage

// ===== rtl/core/deq_mem.sv =====
// entry store: one write port, one read port with registered read data
module deq_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32,
  parameter int AW     = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/double_ended_queue_with_remove.sv =====
// double-ended queue top level: sequencer, ring indices, output register
//
//   channel | ports                    | direction | beat
//   --------+--------------------------+-----------+---------------------------
//   in      | in_valid in_stall in_beat | in        | request (type, value)
//   out     | out_valid out_stall out_beat | out    | result (value, status, counts)
//   cfg     | cfg_we cfg_wdata         | in        | empty read value
//
// push, clear and requests on an empty queue: result registered straight from idle
// pop and peek: result registered in the read state, from the read data of the entry store
// remove-equal: one stored entry read, then moved or dropped, per cycle
// synchronous reset empties the queue and zeroes the empty read value
// a new request is taken only in idle and when the output register is free or draining
`include "double_ended_queue_with_remove_macros.svh"

module double_ended_queue_with_remove
  import deq_pkg::*;
#(
  parameter int DEPTH  = DEQ_DEPTH,
  parameter int DATA_W = DEQ_DATA_W
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fsm_t              state_r, state_nxt;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_i_r, rd_i_nxt;
  logic [CW-1:0]     kept_r, kept_nxt;
  logic [CW-1:0]     rmv_r, rmv_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [31:0]       erv_r;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_beat_r, out_beat_nxt;
  logic              load_out;
  logic              in_take;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // ring position base + off, off never above DEPTH
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  deq_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W),
    .AW     (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handshake
  assign in_stall  = !((state_r == FSM_IDLE) && (!out_valid_r || !out_stall));
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // sequencer, index update and store access
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rd_i_nxt      = rd_i_r;
    kept_nxt      = kept_r;
    rmv_nxt       = rmv_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    load_out      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      FSM_IDLE: begin
        if (in_take) begin
          val_nxt      = DATA_W'(in_beat.item_value);
          out_beat_nxt = '0;
          unique case (req_type_t'(in_beat.req_type))
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              load_out = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                out_beat_nxt.status = STS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = DATA_W'(in_beat.item_value);
                count_nxt = count_r + 1'b1;
                if (req_type_t'(in_beat.req_type) == REQ_PUSH_FRONT) begin
                  front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
                  mem_waddr = front_nxt;
                end else begin
                  mem_waddr = ring_pos(front_r, count_r);
                end
              end
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT: begin
              if (count_r == '0) begin
                load_out                = 1'b1;
                out_beat_nxt.read_value = erv_r;
                out_beat_nxt.status     = STS_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                state_nxt = FSM_READ;
                if (req_type_t'(in_beat.req_type) == REQ_POP_FRONT) begin
                  front_nxt = ring_pos(front_r, CW'(1));
                  count_nxt = count_r - 1'b1;
                end
              end
            end
            REQ_POP_BACK, REQ_PEEK_BACK: begin
              if (count_r == '0) begin
                load_out                = 1'b1;
                out_beat_nxt.read_value = erv_r;
                out_beat_nxt.status     = STS_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ring_pos(front_r, count_r - 1'b1);
                state_nxt = FSM_READ;
                if (req_type_t'(in_beat.req_type) == REQ_POP_BACK) begin
                  count_nxt = count_r - 1'b1;
                end
              end
            end
            REQ_REMOVE: begin
              if (count_r == '0) begin
                load_out = 1'b1;
              end else begin
                // start the compacting walk at the front entry
                mem_re    = 1'b1;
                mem_raddr = front_r;
                rd_i_nxt  = CW'(1);
                kept_nxt  = '0;
                rmv_nxt   = '0;
                state_nxt = FSM_SCAN;
              end
            end
            REQ_CLEAR: begin
              load_out                   = 1'b1;
              out_beat_nxt.removed_count = 5'(count_r);
              count_nxt                  = '0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end

      FSM_READ: begin
        // entry data is registered by the store read issued in idle
        out_beat_nxt            = '0;
        out_beat_nxt.read_value = 32'(mem_rdata);
        load_out                = 1'b1;
        state_nxt               = FSM_IDLE;
      end

      FSM_SCAN: begin
        // drop matches, move kept entries down toward the front
        if (mem_rdata == val_r) begin
          rmv_nxt = rmv_r + 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = ring_pos(front_r, kept_r);
          mem_wdata = mem_rdata;
          kept_nxt  = kept_r + 1'b1;
        end
        if (rd_i_r < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = ring_pos(front_r, rd_i_r);
          rd_i_nxt  = rd_i_r + 1'b1;
        end else begin
          count_nxt                  = kept_nxt;
          out_beat_nxt               = '0;
          out_beat_nxt.removed_count = 5'(rmv_nxt);
          load_out                   = 1'b1;
          state_nxt                  = FSM_IDLE;
        end
      end

      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase

    // counts reported after the request
    if (load_out) begin
      out_valid_nxt            = 1'b1;
      out_beat_nxt.entry_count = 5'(count_nxt);
      out_beat_nxt.is_empty    = (count_nxt == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      erv_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        erv_r <= cfg_wdata;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    rd_i_r     <= rd_i_nxt;
    kept_r     <= kept_nxt;
    rmv_r      <= rmv_nxt;
    val_r      <= val_nxt;
    out_beat_r <= out_beat_nxt;
  end

  // checks
  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "entry count above depth")
  `DEQ_ASSERT_NOW(a_busy_stall, state_r != FSM_IDLE, in_stall, "request taken while busy")
  `DEQ_ASSERT_NOW(a_scan_tally, state_r == FSM_SCAN, (kept_r + rmv_r + 1'b1) == rd_i_r, "walk tally mismatch")
  `DEQ_ASSERT_NEXT(a_read_done, state_r == FSM_READ, out_valid_r && state_r == FSM_IDLE, "read result not loaded")

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the double-ended queue with remove-equal
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  localparam int MAX_WAIT       = 18;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_REPORTS    = 200;
  localparam int SLOT_W         = $clog2(DEQ_DEPTH);

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // shadow copy of the queue state
  logic [31:0] shadow_store [DEQ_DEPTH];
  int          shadow_front     = 0;
  int          shadow_count     = 0;
  logic [31:0] shadow_empty_val = '0;

  out_beat_t   answers_due [$];
  int          mismatch_count = 0;
  int          idle_cycles    = 0;

  // pacing controls for the sender and the result sink
  bit tx_burst      = 1'b0;
  bit rx_burst      = 1'b0;
  bit hold_off_req  = 1'b0;

  double_ended_queue_with_remove u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ring slot of a shadow position
  function automatic logic [SLOT_W-1:0] slot(int pos);
    return SLOT_W'(pos % DEQ_DEPTH);
  endfunction

  // apply one request to the shadow queue and return the answer it gives
  function automatic out_beat_t deque_apply(in_beat_t rq);
    out_beat_t   r;
    logic [31:0] e;
    int          kept;
    int          removed;
    r       = '0;
    removed = 0;
    case (req_type_t'(rq.req_type))
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_count >= DEQ_DEPTH) begin
          r.status = STS_FULL;
        end else if (req_type_t'(rq.req_type) == REQ_PUSH_FRONT) begin
          shadow_front = (shadow_front == 0) ? DEQ_DEPTH - 1 : shadow_front - 1;
          shadow_store[slot(shadow_front)] = rq.item_value;
          shadow_count++;
        end else begin
          shadow_store[slot(shadow_front + shadow_count)] = rq.item_value;
          shadow_count++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (shadow_count == 0) begin
          r.read_value = shadow_empty_val;
          r.status     = STS_EMPTY;
        end else if (req_type_t'(rq.req_type) inside {REQ_POP_FRONT, REQ_PEEK_FRONT}) begin
          r.read_value = shadow_store[slot(shadow_front)];
          if (req_type_t'(rq.req_type) == REQ_POP_FRONT) begin
            shadow_front = (shadow_front + 1) % DEQ_DEPTH;
            shadow_count--;
          end
        end else begin
          r.read_value = shadow_store[slot(shadow_front + shadow_count - 1)];
          if (req_type_t'(rq.req_type) == REQ_POP_BACK) shadow_count--;
        end
      end
      REQ_REMOVE: begin
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          e = shadow_store[slot(shadow_front + i)];
          if (e == rq.item_value) begin
            removed++;
          end else begin
            shadow_store[slot(shadow_front + kept)] = e;
            kept++;
          end
        end
        shadow_count = kept;
      end
      default: begin
        removed      = shadow_count;
        shadow_count = 0;
      end
    endcase
    r.entry_count   = shadow_count[4:0];
    r.removed_count = removed[4:0];
    r.is_empty      = (shadow_count == 0);
    return r;
  endfunction

  // one line per mismatch, printing capped to keep the log short
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // compare one result beat with the oldest answer due
  task automatic check_answer(out_beat_t got);
    out_beat_t want;
    if (answers_due.size() == 0) begin
      report_mismatch("result with nothing due", got.read_value, '0);
    end else begin
      want = answers_due.pop_front();
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      if (got.removed_count !== want.removed_count)
        report_mismatch("removed_count", 32'(got.removed_count), 32'(want.removed_count));
      if (got.is_empty !== want.is_empty)
        report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
    end
  endtask

  // monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_answer(out_beat);
      if (in_valid && !in_stall) answers_due.push_back(deque_apply(in_beat));
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // result sink: random stall before each beat unless in burst mode, plus a long hold-off on request
  initial begin : result_sink
    int unsigned wait_cycles;
    int          hold_cnt;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(negedge clk);
        hold_off_req = 1'b0;
      end
      wait_cycles = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // send one request beat; entered and left at a falling edge
  task automatic send_request(req_type_t kind, logic [31:0] value);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{req_type: kind, item_value: value};
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // stop sending and wait until every answer has come back
  task automatic drain_all();
    in_valid <= 1'b0;
    do @(negedge clk); while (answers_due.size() != 0);
  endtask

  // register write while the queue is idle
  task automatic write_empty_value(logic [31:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow_empty_val = value;
  endtask

  // reads, remove and clear on an empty queue, two empty values
  task automatic test_empty_reads();
    send_request(REQ_POP_FRONT, 32'h1234_5678);
    send_request(REQ_PEEK_BACK, 32'h0);
    drain_all();
    write_empty_value(32'hFFFF_FFFF);
    send_request(REQ_POP_BACK, 32'hFFFF_FFFF);
    send_request(REQ_PEEK_FRONT, 32'h0);
    send_request(REQ_REMOVE, 32'h0);
    send_request(REQ_CLEAR, 32'hFFFF_FFFF);
    drain_all();
  endtask

  // pushes, peeks and pops at both ends, then remove and clear
  task automatic test_basic_ops();
    send_request(REQ_PUSH_FRONT, 32'h0000_0000);
    send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(REQ_PUSH_BACK, 32'h5555_5555);
    send_request(REQ_PEEK_FRONT, 32'h0);
    send_request(REQ_PEEK_BACK, 32'h0);
    send_request(REQ_POP_FRONT, 32'h0);
    send_request(REQ_POP_BACK, 32'h0);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF);
    send_request(REQ_CLEAR, 32'h0);
    drain_all();
  endtask

  // fill to the limit, push into a full queue, remove half
  task automatic test_full();
    for (int i = 0; i < DEQ_DEPTH; i++)
      send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                   i[1] ? 32'hA5A5_0F0F : 32'h5A5A_F0F0);
    send_request(REQ_PUSH_FRONT, 32'h1111_1111);
    send_request(REQ_PUSH_BACK, 32'h2222_2222);
    send_request(REQ_PEEK_BACK, 32'h0);
    send_request(REQ_REMOVE, 32'hA5A5_0F0F);
    send_request(REQ_POP_FRONT, 32'h0);
    send_request(REQ_CLEAR, 32'h0);
    drain_all();
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    write_empty_value(32'h0);
    tx_burst     = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_request((i < 20) ? REQ_PUSH_BACK : REQ_PEEK_FRONT, $urandom);
    drain_all();
    tx_burst = 1'b0;
  endtask

  // random phases: each with its own empty value, value pool and pacing
  task automatic test_random(int phases, int per_phase);
    logic [31:0] pool [4];
    logic [31:0] value;
    req_type_t   kind;
    bit          grow;
    bit          side;
    int unsigned roll;
    for (int p = 0; p < phases; p++) begin
      drain_all();
      case (p % 3)
        0:       write_empty_value(32'h0);
        1:       write_empty_value(32'hFFFF_FFFF);
        default: write_empty_value($urandom);
      endcase
      pool[0] = $urandom;
      pool[1] = $urandom;
      pool[2] = p[0] ? 32'h0 : $urandom;
      pool[3] = 32'hFFFF_FFFF;
      grow    = 1'b1;
      for (int i = 0; i < per_phase; i++) begin
        // redraw the mix and the pacing now and then
        if (i % 40 == 0) begin
          if (i != 0) grow = 1'($urandom_range(0, 1));
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        roll = $urandom_range(0, 99);
        side = 1'($urandom_range(0, 1));
        if (roll < (grow ? 65 : 25))      kind = side ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else if (roll < (grow ? 80 : 70)) kind = side ? REQ_POP_BACK : REQ_POP_FRONT;
        else if (roll < 90)               kind = side ? REQ_PEEK_BACK : REQ_PEEK_FRONT;
        else if (roll < 99)               kind = REQ_REMOVE;
        else                              kind = REQ_CLEAR;
        value = ($urandom_range(0, 9) < 7) ? pool[2'($urandom_range(0, 3))] : $urandom;
        send_request(kind, value);
      end
    end
    drain_all();
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // reset, tests in turn, then the verdict
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_reads();
    test_basic_ops();
    test_full();
    test_backpressure();
    test_random(7, 200);
    drain_all();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (answers_due.size() != 0)
      report_mismatch("results never seen", answers_due.size(), 0);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue_with_remove.f =====
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_mem.sv
rtl/core/double_ended_queue_with_remove.sv
tb/testbench.sv
